// ===== sv/humidity_temperature_compensator_defines.svh =====
// Assertion macros for the humidity/temperature compensator.
// No dependencies; included by the top level.
`ifndef HUMIDITY_TEMPERATURE_COMPENSATOR_DEFINES_SVH
`define HUMIDITY_TEMPERATURE_COMPENSATOR_DEFINES_SVH

// Condition implies consequence in the same cycle
`define HTC_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("htc check failed");

// Condition implies consequence in the next cycle
`define HTC_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("htc check failed");

`endif

// ===== sv/htc_pkg.sv =====
// Shared types, constants and conversion functions for the compensator.
// No dependencies; used by htc_counters and the top level.
`timescale 1ns / 1ps

package htc_pkg;

   // Field widths
   localparam int unsigned HOLD_W  = 12;
   localparam int unsigned LEVEL_W = 7;
   localparam int unsigned RAW_W   = 16;
   localparam int unsigned DISP_W  = 8;
   localparam int unsigned MAG_W   = 13;  // |numerator| >> 16
   localparam int unsigned TENTH_W = 11;  // value in tenths before the final /10

   localparam logic [HOLD_W-1:0] HOLD_RESET = 12'd600;
   localparam logic [HOLD_W-1:0] COUNT_MAX  = 12'd4095;
   localparam logic [LEVEL_W-1:0] LEVEL_FULL = 7'd100;
   localparam logic [DISP_W-1:0] TEMP_RESET = 8'd40;

   // Sequencer phases
   typedef enum logic [1:0] {
      PH_REQ_HUM  = 2'd0,
      PH_HUM      = 2'd1,
      PH_REQ_TEMP = 2'd2,
      PH_TEMP     = 2'd3
   } phase_type;

   // Linear conversion constants: n = GAIN * raw - OFFSET
   localparam logic [13:0] HUM_GAIN   = 14'd1250;
   localparam logic [29:0] HUM_OFFS   = 30'd3932160;
   localparam logic [13:0] TEMP_GAIN  = 14'd8786;
   localparam logic [29:0] TEMP_OFFS  = 30'd153518080;

   // Reciprocals for small exact divisions (value * R >> 16)
   localparam logic [13:0] RECIP_5  = 14'd13108;
   localparam logic [12:0] RECIP_10 = 13'd6554;

   // Per-tick sequencer status handed from the counter block
   typedef struct packed {
      phase_type  handled;  // phase of this transaction
      logic       heat;     // self-heating correction applies
   } htc_tick_type;

   // Humidity in tenths plus 80, from the signed magnitude of h10
   function automatic logic [TENTH_W-1:0] hum_tenths(input logic neg,
                                                     input logic [MAG_W-1:0] mag);
      logic [TENTH_W-1:0] m;
      begin
         m = TENTH_W'(mag);
         hum_tenths = neg ? (TENTH_W'(80) - m) : (TENTH_W'(80) + m);
      end
   endfunction

   // Offset temperature in tenths: clamp, piecewise offset, self-heating
   function automatic logic [TENTH_W-1:0] temp_tenths(input logic neg,
                                                      input logic [MAG_W-1:0] mag,
                                                      input logic heat);
      logic [MAG_W+13:0]  prod;
      logic [TENTH_W-1:0] q;
      logic [TENTH_W-1:0] b;
      logic [TENTH_W-1:0] off;
      begin
         prod = mag * RECIP_5;
         q    = prod[TENTH_W+15:16];
         // clamp at -40.0 C, then shift to a zero-based value
         if (neg) begin
            b = (q > TENTH_W'(400)) ? '0 : (TENTH_W'(400) - q);
         end else begin
            b = TENTH_W'(400) + q;
         end
         if (b >= TENTH_W'(650)) begin
            off = TENTH_W'(40);
         end else if (b >= TENTH_W'(600)) begin
            off = TENTH_W'(45);
         end else if (b >= TENTH_W'(550)) begin
            off = TENTH_W'(50);
         end else if (b >= TENTH_W'(450)) begin
            off = TENTH_W'(55);
         end else begin
            off = TENTH_W'(60);
         end
         b = (b > off) ? (b - off) : '0;
         if (heat) begin
            b = (b > TENTH_W'(10)) ? (b - TENTH_W'(10)) : '0;
         end
         temp_tenths = b;
      end
   endfunction

   // Exact x / 10 for every 11-bit x (x below 2048)
   function automatic logic [DISP_W-1:0] div10(input logic [TENTH_W-1:0] x);
      logic [TENTH_W+12:0] prod;
      begin
         prod  = x * RECIP_10;
         div10 = prod[DISP_W+15:16];
      end
   endfunction

endpackage

// ===== sv/htc_counters.sv =====
// Phase sequencer and charge / cooldown counters of the compensator.
// Depends on htc_pkg.
`timescale 1ns / 1ps

module htc_counters (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        tick,          // transaction accepted
   input  logic                        suspend,
   input  logic                        charging,
   input  logic [htc_pkg::LEVEL_W-1:0] battery_level,
   input  logic [htc_pkg::HOLD_W-1:0]  hold,
   output htc_pkg::htc_tick_type       status
);
   import htc_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [HOLD_W-1:0] charge_ff, charge_in;
   logic [HOLD_W-1:0] cool_ff, cool_in;

   // Next counter and phase values for this tick
   always_comb begin
      phase_in  = phase_ff;
      charge_in = charge_ff;
      cool_in   = cool_ff;
      status.handled = PH_REQ_HUM;
      if (suspend) begin
         phase_in  = PH_REQ_HUM;
         charge_in = '0;
         cool_in   = '0;
      end else begin
         if (charging && (battery_level < LEVEL_FULL)) begin
            if (charge_ff > hold) begin
               charge_in = hold;
               cool_in   = hold;
            end else if (charge_ff < COUNT_MAX) begin
               charge_in = charge_ff + 1'b1;
            end
         end else begin
            if (charge_ff != '0) begin
               charge_in = charge_ff - 1'b1;
            end
            if (cool_ff != '0) begin
               cool_in = cool_ff - 1'b1;
            end
         end
         status.handled = phase_ff;
         phase_in = phase_type'(phase_ff + 2'd1);
      end
      // heating check sees the counters as updated this tick
      status.heat = (cool_in != '0) || (charge_in >= hold);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_REQ_HUM;
         charge_ff <= '0;
         cool_ff   <= '0;
      end else if (tick) begin
         phase_ff  <= phase_in;
         charge_ff <= charge_in;
         cool_ff   <= cool_in;
      end
   end

endmodule

// ===== sv/humidity_temperature_compensator.sv =====
// Top level of the humidity/temperature compensator: three-stage pipeline.
// Depends on htc_pkg, htc_counters and humidity_temperature_compensator_defines.svh.
`timescale 1ns / 1ps
`include "humidity_temperature_compensator_defines.svh"

// Usage
// - req channel: one transaction per tick carrying suspend, charging,
//   battery level and the raw sensor word. Every transaction yields exactly
//   one rsp transaction with the display values and the phase handled.
// - csr port: csr_we with csr_wdata loads the charge hold value; write it only
//   while no transaction is in flight.
// - Path: an accepted transaction passes the sensor multiply stage, the
//   clamp/offset stage and the divide-by-ten/display stage in that order;
//   rsp_tvalid rises once the result register has been loaded.
// - Throughput: one transaction per cycle unless rsp_tready stalls; counters
//   and phase update at acceptance, so consecutive ticks need no spacing.
// - Stall: when rsp_tready is low the result register holds; the stages
//   behind it keep filling, and req_tready drops once all three are full.
// - Reset: phase and counters cleared, humidity 0, temperature display 40
//   (0 C), hold value 600, pipeline empty.
module humidity_temperature_compensator (
   input  logic                       clock,
   input  logic                       reset,
   // fields from bit 0: suspend, charging, battery_level[6:0], raw_word[15:0]
   input  logic [31:0]                req_tdata,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // fields from bit 0: humidity_pct[7:0], temperature_disp[7:0]
   output logic [15:0]                rsp_tdata,
   // fields from bit 0: phase_handled[1:0]
   output logic [1:0]                 rsp_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic                       csr_we,
   input  logic [htc_pkg::HOLD_W-1:0] csr_wdata
);
   import htc_pkg::*;

   logic               suspend;
   logic               charging;
   logic [LEVEL_W-1:0] battery_level;
   logic [RAW_W-1:0]   raw_word;

   logic               accept;
   logic               out_ready, s2_ready, s1_ready;
   htc_tick_type       tick_status;

   logic [HOLD_W-1:0]  hold_ff;

   // stage 1: magnitude of the scaled sensor numerator
   logic               s1_valid_ff;
   phase_type          s1_phase_ff;
   logic               s1_heat_ff;
   logic               s1_neg_ff, s1_neg_in;
   logic [MAG_W-1:0]   s1_mag_ff, s1_mag_in;

   // stage 2: value in tenths ready for the final divide
   logic               s2_valid_ff;
   phase_type          s2_phase_ff;
   logic [TENTH_W-1:0] s2_val_ff, s2_val_in;

   // stage 3: display registers and result
   logic               rsp_valid_ff;
   phase_type          rsp_phase_ff;
   logic [DISP_W-1:0]  hum_ff, temp_ff;
   logic [DISP_W-1:0]  quot;

   logic [13:0]        gain;
   logic [29:0]        offs;
   logic [29:0]        prod;
   logic [29:0]        diff;

   assign suspend       = req_tdata[0];
   assign charging      = req_tdata[1];
   assign battery_level = req_tdata[8:2];
   assign raw_word      = req_tdata[24:9];

   // Handshake chain: a stage loads when it is empty or its data moves on
   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || out_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;
   assign accept     = req_tvalid && s1_ready;

   // Hold value register
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= HOLD_RESET;
      end else if (csr_we) begin
         hold_ff <= csr_wdata;
      end
   end

   htc_counters u_counters (
      .clock         (clock),
      .reset         (reset),
      .tick          (accept),
      .suspend       (suspend),
      .charging      (charging),
      .battery_level (battery_level),
      .hold          (hold_ff),
      .status        (tick_status)
   );

   // Stage 1 datapath: one constant-select multiply and subtract
   always_comb begin
      if (tick_status.handled == PH_TEMP) begin
         gain = TEMP_GAIN;
         offs = TEMP_OFFS;
      end else begin
         gain = HUM_GAIN;
         offs = HUM_OFFS;
      end
      prod      = gain * raw_word;
      s1_neg_in = prod < offs;
      diff      = s1_neg_in ? (offs - prod) : (prod - offs);
      s1_mag_in = diff[MAG_W+15:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_phase_ff <= tick_status.handled;
         s1_heat_ff  <= tick_status.heat;
         s1_neg_ff   <= s1_neg_in;
         s1_mag_ff   <= s1_mag_in;
      end
   end

   // Stage 2 datapath: humidity shift or temperature clamp/offset/heating
   always_comb begin
      if (s1_phase_ff == PH_TEMP) begin
         s2_val_in = temp_tenths(s1_neg_ff, s1_mag_ff, s1_heat_ff);
      end else begin
         s2_val_in = hum_tenths(s1_neg_ff, s1_mag_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_phase_ff <= s1_phase_ff;
         s2_val_ff   <= s2_val_in;
      end
   end

   // Stage 3: final divide by ten into the display registers
   assign quot = div10(s2_val_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_phase_ff <= PH_REQ_HUM;
         hum_ff       <= '0;
         temp_ff      <= TEMP_RESET;
      end else if (out_ready) begin
         rsp_valid_ff <= s2_valid_ff;
         if (s2_valid_ff) begin
            rsp_phase_ff <= s2_phase_ff;
            case (s2_phase_ff)
               PH_HUM:  hum_ff  <= quot;
               PH_TEMP: temp_ff <= quot;
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {temp_ff, hum_ff};
   assign rsp_tuser  = rsp_phase_ff;

   // Checks
   `HTC_ASSERT_NEXT(a_accept_fills_s1, clock, reset, accept, s1_valid_ff)
   `HTC_ASSERT_NEXT(a_request_phase_keeps_display, clock, reset,
      s2_valid_ff && out_ready && (s2_phase_ff == PH_REQ_HUM || s2_phase_ff == PH_REQ_TEMP),
      $stable(hum_ff) && $stable(temp_ff))
   `HTC_ASSERT_SAME(a_display_range, clock, reset, rsp_valid_ff,
      hum_ff <= 8'd127 && temp_ff <= 8'd168)

endmodule
